// ----- rtl/rle_memory_fill_decoder_macros.svh -----
// assertion macros shared by the decoder checkers
// no dependencies; pulled in by the checker file
`ifndef RLE_MEMORY_FILL_DECODER_MACROS_SVH
`define RLE_MEMORY_FILL_DECODER_MACROS_SVH

// same-cycle implication, disabled in reset
`define RMFD_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("rmfd check failed");

// next-cycle implication, disabled in reset
`define RMFD_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("rmfd check failed");

`endif

// ----- rtl/rmfd_pkg.sv -----
// types and constants for the run-length memory fill decoder
// no dependencies; used by all decoder modules
package rmfd_pkg;

  localparam int WORD_W  = 32;
  localparam int COUNT_W = 31;
  localparam int LITERAL_BIT = 31;
  localparam logic [WORD_W-1:0] ADDR_STEP = 32'd4;

  typedef enum logic [2:0] {
    ST_HEADER,
    ST_ADDRESS,
    ST_LITERAL,
    ST_REPEAT,
    ST_BURST
  } state_t;

  typedef struct packed {
    logic load_addr;
    logic load_count;
    logic clear_count;
    logic emit_literal;
    logic emit_error;
    logic start_burst;
    logic emit_burst;
  } cmd_t;

  typedef struct packed {
    logic hdr_zero;
    logic hdr_literal;
    logic lit_empty;
    logic hdr_oversize;
    logic count_zero;
    logic count_one;
    logic out_free;
  } status_t;

endpackage

// ----- rtl/rmfd_if.sv -----
// valid/ready channel interfaces for the decoder
// spec word input and memory write output; no dependencies
interface rmfd_spec_if;
  logic        valid;
  logic        ready;
  logic [31:0] spec_word;
  logic        final_word;

  modport source (output valid, spec_word, final_word, input ready);
  modport sink   (input valid, spec_word, final_word, output ready);
endinterface

interface rmfd_write_if;
  logic        valid;
  logic        ready;
  logic [31:0] write_address;
  logic [31:0] write_data;
  logic        run_last;
  logic        run_error;

  modport source (output valid, write_address, write_data, run_last, run_error,
                  input ready);
  modport sink   (input valid, write_address, write_data, run_last, run_error,
                  output ready);
endinterface

// ----- rtl/rmfd_ctrl.sv -----
// decoder controller: phase state machine issuing datapath commands
// depends on rmfd_pkg
module rmfd_ctrl
  import rmfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  input  logic    final_word,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;
  logic   accept;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HEADER;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = status.out_free && (state != ST_BURST);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_HEADER: begin
        if (accept) begin
          priority if (status.hdr_zero) begin
            state_next = ST_ADDRESS;
          end else if (status.hdr_literal) begin
            cmd.load_count = 1'b1;
            state_next = status.lit_empty ? ST_HEADER : ST_LITERAL;
          end else if (status.hdr_oversize) begin
            // error result now, value word swallowed later
            cmd.emit_error  = 1'b1;
            cmd.clear_count = 1'b1;
            state_next = ST_REPEAT;
          end else begin
            cmd.load_count = 1'b1;
            state_next = ST_REPEAT;
          end
        end
      end
      ST_ADDRESS: begin
        if (accept) begin
          cmd.load_addr = 1'b1;
          state_next = ST_HEADER;
        end
      end
      ST_LITERAL: begin
        if (accept) begin
          cmd.emit_literal = 1'b1;
          state_next = status.count_one ? ST_HEADER : ST_LITERAL;
        end
      end
      ST_REPEAT: begin
        if (accept) begin
          if (status.count_zero) begin
            state_next = ST_HEADER;
          end else begin
            cmd.start_burst = 1'b1;
            state_next = ST_BURST;
          end
        end
      end
      ST_BURST: begin
        if (status.out_free) begin
          cmd.emit_burst = 1'b1;
          if (status.count_one) begin
            state_next = ST_HEADER;
          end
        end
      end
      default: begin
        state_next = ST_HEADER;
      end
    endcase

    // last stream word: back to header, unless a repeat run still has writes
    if (accept && final_word && !cmd.start_burst) begin
      state_next      = ST_HEADER;
      cmd.clear_count = 1'b1;
    end
  end

endmodule

// ----- rtl/rmfd_datapath.sv -----
// decoder datapath: address, count, repeat value and output register
// depends on rmfd_pkg
module rmfd_datapath
  import rmfd_pkg::*;
#(
  parameter int MAX_RUN = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [WORD_W-1:0] spec_word,
  input  cmd_t              cmd,
  output status_t           status,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [WORD_W-1:0] write_address,
  output logic [WORD_W-1:0] write_data,
  output logic              run_last,
  output logic              run_error
);

  logic [WORD_W-1:0]  current_address;
  logic [COUNT_W-1:0] count;
  logic [WORD_W-1:0]  rep_data;
  logic               emit_any;

  assign emit_any = cmd.emit_literal || cmd.emit_error || cmd.emit_burst;

  assign status.hdr_zero     = (spec_word == '0);
  assign status.hdr_literal  = spec_word[LITERAL_BIT];
  assign status.lit_empty    = (spec_word[COUNT_W-1:0] == '0);
  assign status.hdr_oversize = (spec_word > WORD_W'(MAX_RUN));
  assign status.count_zero   = (count == '0);
  assign status.count_one    = (count == COUNT_W'(1));
  assign status.out_free     = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      current_address <= '0;
      count           <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cmd.load_addr) begin
        current_address <= spec_word;
      end else if (cmd.emit_literal || cmd.emit_burst) begin
        current_address <= current_address + ADDR_STEP;
      end

      priority if (cmd.clear_count) begin
        count <= '0;
      end else if (cmd.load_count) begin
        count <= spec_word[COUNT_W-1:0];
      end else if (cmd.emit_literal || cmd.emit_burst) begin
        count <= count - COUNT_W'(1);
      end

      if (emit_any) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_burst) begin
      rep_data <= spec_word;
    end
    if (emit_any) begin
      write_address <= current_address;
      run_error     <= cmd.emit_error;
      priority if (cmd.emit_error) begin
        write_data <= '0;
        run_last   <= 1'b1;
      end else if (cmd.emit_literal) begin
        write_data <= spec_word;
        run_last   <= 1'b1;
      end else begin
        write_data <= rep_data;
        run_last   <= status.count_one;
      end
    end
  end

endmodule

// ----- rtl/rle_memory_fill_decoder.sv -----
// channel     | dir | payload                                         | moves when
// ------------+-----+-------------------------------------------------+-------------
// spec_in     | in  | spec_word[31:0], final_word                     | valid & ready
// wr_out      | out | write_address, write_data, run_last, run_error  | valid & ready
//
// an address word produces no write and a literal word one write; a repeat value word starts a run
// of writes (up to MAX_RUN) through the single output register, and input is held off while the
// run drains.
// a stalled output register holds the input off as well.
// synchronous reset returns the decoder to expecting a header with address zero.
// depends on rmfd_pkg, rmfd_if, rmfd_ctrl, rmfd_datapath
module rle_memory_fill_decoder
  import rmfd_pkg::*;
#(
  parameter int MAX_RUN = 64
) (
  input  logic         clk,
  input  logic         rst,
  rmfd_spec_if.sink    spec_in,
  rmfd_write_if.source wr_out
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign spec_in.ready = in_ready;

  rmfd_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (spec_in.valid),
    .final_word (spec_in.final_word),
    .in_ready   (in_ready),
    .status     (status),
    .cmd        (cmd)
  );

  rmfd_datapath #(
    .MAX_RUN (MAX_RUN)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .spec_word     (spec_in.spec_word),
    .cmd           (cmd),
    .status        (status),
    .out_valid     (wr_out.valid),
    .out_ready     (wr_out.ready),
    .write_address (wr_out.write_address),
    .write_data    (wr_out.write_data),
    .run_last      (wr_out.run_last),
    .run_error     (wr_out.run_error)
  );

endmodule

// ----- rtl/rmfd_checker.sv -----
// port-level checks for the decoder, bound to the top level
// depends on rle_memory_fill_decoder_macros.svh
`include "rle_memory_fill_decoder_macros.svh"

module rmfd_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] write_address,
  input logic [31:0] write_data,
  input logic        run_last,
  input logic        run_error
);

  // error results are single, data-free transactions
  `RMFD_ASSERT_NOW(a_error_shape, clk, rst, out_valid && run_error, run_last && write_data == '0)
  // a full, stalled output register holds the input off
  `RMFD_ASSERT_NOW(a_stall_blocks_in, clk, rst, out_valid && !out_ready, !in_ready)
  // repeat runs stream without gaps until their last write
  `RMFD_ASSERT_NEXT(a_run_no_gap, clk, rst, out_valid && out_ready && !run_last, out_valid)
  // a stalled write keeps its payload
  `RMFD_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && !out_ready,
    out_valid && $stable(write_address) && $stable(write_data) && $stable(run_last))

endmodule

bind rle_memory_fill_decoder rmfd_checker u_rmfd_checker (
  .clk           (clk),
  .rst           (rst),
  .in_ready      (spec_in.ready),
  .out_valid     (wr_out.valid),
  .out_ready     (wr_out.ready),
  .write_address (wr_out.write_address),
  .write_data    (wr_out.write_data),
  .run_last      (wr_out.run_last),
  .run_error     (wr_out.run_error)
);
